// File: rtl/core/dllw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllw_pkg
// shared types, codes and helpers of the dma linked list walker
// ----------------------------------------------------------------------------
package dllw_pkg;

  localparam int ADDR_W      = 21;
  localparam int WIDX_W      = ADDR_W - 2;
  localparam int WORD_W      = 32;
  localparam int BASE_W      = 24;
  localparam int COUNT_W     = 8;
  localparam int COUNT_LSB   = 24;
  localparam int END_BIT     = 23;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int PADDR_W     = 3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_WORD  = 1'b1;

  localparam logic REG_LIST_BASE = 1'b0;
  localparam logic REG_FROM_RAM  = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_PORT   = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_DIRERR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   mem_address;
    logic [WORD_W-1:0]   port_word;
    logic                last;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic              from_ram;
    logic [BASE_W-1:0] list_base;
  } cfg_t;

  typedef struct packed {
    logic   empty;
    entry_t entry;
  } fifo_rd_t;

  function automatic result_t make_result(kind_t kind, logic [WIDX_W-1:0] widx,
                                          logic [WORD_W-1:0] word);
    result_t r;
    r.kind        = kind;
    r.mem_address = (kind == KIND_READ) ? {widx, 2'b00} : '0;
    r.port_word   = (kind == KIND_PORT) ? word : '0;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/core/dllw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllw_front
// accepts start and memory-word transfers, walks the list, queues results
// ----------------------------------------------------------------------------
module dllw_front import dllw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [WORD_W-1:0] in_mem_word,
  input  logic              fifo_full,
  output logic              push,
  output entry_t            push_entry
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [WIDX_W-1:0]   cur_r, cur_nxt;
  logic [COUNT_W-1:0]  wl_r, wl_nxt;
  logic [WIDX_W-1:0]   link_r, link_nxt;
  logic                end_r, end_nxt;
  logic                accept;
  logic                has_result;
  entry_t              ent;

  assign in_stall   = fifo_full;
  assign accept     = in_valid && !in_stall;
  assign push       = accept && has_result;
  assign push_entry = ent;

  always_comb begin
    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    wl_nxt     = wl_r;
    link_nxt   = link_r;
    end_nxt    = end_r;
    ent        = '0;
    has_result = 1'b0;
    if (in_req_type == REQ_START) begin
      has_result = 1'b1;
      if (!cfg.from_ram) begin
        ent.r0    = make_result(KIND_DIRERR, '0, '0);
        phase_nxt = PH_IDLE;
      end else begin
        cur_nxt   = cfg.list_base[ADDR_W-1:2];
        wl_nxt    = '0;
        end_nxt   = 1'b0;
        ent.r0    = make_result(KIND_READ, cur_nxt, '0);
        phase_nxt = PH_HEADER;
      end
    end else begin
      case (phase_r)
        PH_HEADER: begin
          has_result = 1'b1;
          wl_nxt     = in_mem_word[COUNT_LSB +: COUNT_W];
          link_nxt   = in_mem_word[ADDR_W-1:2];
          end_nxt    = in_mem_word[END_BIT];
          if (wl_nxt != '0) begin
            cur_nxt   = cur_r + WIDX_W'(1);
            ent.r0    = make_result(KIND_READ, cur_nxt, '0);
            phase_nxt = PH_DATA;
          end else if (end_nxt) begin
            ent.r0    = make_result(KIND_DONE, '0, '0);
            phase_nxt = PH_IDLE;
          end else begin
            cur_nxt   = link_nxt;
            ent.r0    = make_result(KIND_READ, cur_nxt, '0);
            phase_nxt = PH_HEADER;
          end
        end
        PH_DATA: begin
          has_result = 1'b1;
          ent.two    = 1'b1;
          ent.r0     = make_result(KIND_PORT, '0, in_mem_word);
          wl_nxt     = wl_r - COUNT_W'(1);
          if (wl_nxt != '0) begin
            cur_nxt   = cur_r + WIDX_W'(1);
            ent.r1    = make_result(KIND_READ, cur_nxt, '0);
            phase_nxt = PH_DATA;
          end else if (end_r) begin
            ent.r1    = make_result(KIND_DONE, '0, '0);
            phase_nxt = PH_IDLE;
          end else begin
            cur_nxt   = link_r;
            ent.r1    = make_result(KIND_READ, cur_nxt, '0);
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (ent.two) begin
      ent.r1.last = 1'b1;
    end else begin
      ent.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cur_r   <= '0;
      wl_r    <= '0;
      link_r  <= '0;
      end_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      wl_r    <= wl_nxt;
      link_r  <= link_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

// File: rtl/core/dllw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllw_fifo
// short queue of result entries between the front and back parts
// ----------------------------------------------------------------------------
module dllw_fifo import dllw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  entry_t   push_entry,
  input  logic     pop,
  output logic     full,
  output fifo_rd_t rd
);

  entry_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign full     = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign rd.empty = (cnt_r == '0);
  assign rd.entry = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !rd.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(do_push);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(do_pop);
    cnt_nxt    = cnt_r + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + FIFO_CNT_W'(1))
    else $error("queue count missed a push");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule

// File: rtl/core/dllw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllw_back
// drains queued entries and presents one result per transfer
// ----------------------------------------------------------------------------
module dllw_back import dllw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  fifo_rd_t rd,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output result_t  out_res
);

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    pend_valid_r, pend_valid_nxt;
  result_t pend_r, pend_nxt;
  logic    load;

  assign load      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    pop            = 1'b0;
    if (load) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = pend_r;
        pend_valid_nxt = 1'b0;
      end else if (!rd.empty) begin
        pop            = 1'b1;
        out_valid_nxt  = 1'b1;
        out_res_nxt    = rd.entry.r0;
        pend_valid_nxt = rd.entry.two;
        pend_nxt       = rd.entry.r1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
    out_res_r <= out_res_nxt;
    pend_r    <= pend_nxt;
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("second result held without a first one on the port");

  a_pend_is_second: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> !out_res_r.last)
    else $error("first result of a pair marked last");

  a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !pend_valid_r && !rd.empty)
    else $error("queue popped while a result is pending");

endmodule

// File: rtl/core/dma_linked_list_walker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_linked_list_walker_top
// linked list walker of one dma channel: register port, front, queue, back
// ----------------------------------------------------------------------------
// channel   direction  handshake         payload
// in        input      in_valid/stall    in_req_type, in_mem_word
// out       output     out_valid/stall   out_result_kind, out_mem_address,
//                                        out_port_word, out_last_of_run
// cfg       input      apb write/read    paddr, pwdata, prdata
//
// an input transfer is taken every cycle while the 4-entry queue has room
// a data word yields two results, which the single result port presents one
// after the other; other items yield at most one result
// the first result of an input transfer is queued, then registered at the output
// reset is synchronous, active low, and leaves the walker idle
// out_stall only fills the queue; in_stall rises when the queue is full
// ----------------------------------------------------------------------------
module dma_linked_list_walker_top import dllw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [WORD_W-1:0]  in_mem_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [ADDR_W-1:0]  out_mem_address,
  output logic [WORD_W-1:0]  out_port_word,
  output logic               out_last_of_run,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t     cfg_r, cfg_nxt;
  logic     reg_sel;
  logic     push;
  entry_t   push_entry;
  logic     pop;
  logic     fifo_full;
  fifo_rd_t rd;
  result_t  out_res;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_LIST_BASE: cfg_nxt.list_base = pwdata[BASE_W-1:0];
        REG_FROM_RAM:  cfg_nxt.from_ram  = pwdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LIST_BASE: prdata = {{(32-BASE_W){1'b0}}, cfg_r.list_base};
      REG_FROM_RAM:  prdata = {31'b0, cfg_r.from_ram};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.list_base <= '0;
      cfg_r.from_ram  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dllw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_mem_word (in_mem_word),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  dllw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (fifo_full),
    .rd         (rd)
  );

  dllw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (rd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_result_kind = out_res.kind;
  assign out_mem_address = out_res.mem_address;
  assign out_port_word   = out_res.port_word;
  assign out_last_of_run = out_res.last;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for dma_linked_list_walker_top: a directed table of
// walks, then random walks under several register settings; each output
// transfer matched to a listed result or to a cycle-free model of the list walk
// ----------------------------------------------------------------------------
module testbench;
  import dllw_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_MASK    = 21'h1ffffc;
  localparam int                LIMIT_CYCLES = 400000;
  localparam int                SETTLE       = 8;

  typedef enum logic [1:0] {WALK_IDLE, WALK_HEADER, WALK_DATA} walk_phase_t;

  typedef struct packed {
    logic              is_cfg;
    logic              sel;
    logic [WORD_W-1:0] val;
    logic              typed;
    logic [1:0]        n_known;
    result_t           k0;
    result_t           k1;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_req_type = REQ_START;
  logic [WORD_W-1:0]  in_mem_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_result_kind;
  logic [ADDR_W-1:0]  out_mem_address;
  logic [WORD_W-1:0]  out_port_word;
  logic               out_last_of_run;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // walk model state and register copies
  walk_phase_t       walk_phase = WALK_IDLE;
  logic [ADDR_W-1:0] cur_addr = '0;
  logic [ADDR_W-1:0] link_addr = '0;
  logic [7:0]        words_left = '0;
  logic              end_seen = 1'b0;
  logic [BASE_W-1:0] base_reg = '0;
  logic              from_ram_reg = 1'b1;

  result_t pending_results[$];
  row_t    dir_rows[$];
  int      err_count = 0;
  int      results_seen = 0;
  int      items_sent = 0;
  int      cycles = 0;
  int      send_gap_pct = 10;
  int      recv_stall_pct = 5;
  bit      long_hold_req = 1'b0;

  dma_linked_list_walker_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_mem_word     (in_mem_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_mem_address (out_mem_address),
    .out_port_word   (out_port_word),
    .out_last_of_run (out_last_of_run),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever begin
      #6 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_results.size());
    $display("dma_linked_list_walker_top verification failed");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic result_t mk(input kind_t k, input logic [ADDR_W-1:0] a,
                                 input logic [WORD_W-1:0] w, input logic l);
    result_t r;
    r.kind        = k;
    r.mem_address = a;
    r.port_word   = w;
    r.last        = l;
    return r;
  endfunction

  // next read of the packet, or the link, or done
  function automatic result_t walk_advance();
    if (words_left != 0) begin
      cur_addr   = (cur_addr + 21'd4) & ADDR_MASK;
      walk_phase = WALK_DATA;
      return mk(KIND_READ, cur_addr, '0, 1'b0);
    end
    if (end_seen) begin
      walk_phase = WALK_IDLE;
      return mk(KIND_DONE, '0, '0, 1'b0);
    end
    cur_addr   = link_addr;
    walk_phase = WALK_HEADER;
    return mk(KIND_READ, cur_addr, '0, 1'b0);
  endfunction

  function automatic int predict_walk(input logic req, input logic [WORD_W-1:0] word,
                                      output result_t out0, output result_t out1);
    result_t res [2];
    int      n;
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    if (req == REQ_START) begin
      if (!from_ram_reg) begin
        res[0]     = mk(KIND_DIRERR, '0, '0, 1'b0);
        walk_phase = WALK_IDLE;
      end else begin
        cur_addr   = base_reg[ADDR_W-1:0] & ADDR_MASK;
        words_left = '0;
        end_seen   = 1'b0;
        res[0]     = mk(KIND_READ, cur_addr, '0, 1'b0);
        walk_phase = WALK_HEADER;
      end
      n = 1;
    end else if (walk_phase == WALK_HEADER) begin
      words_left = word[COUNT_LSB +: COUNT_W];
      link_addr  = word[ADDR_W-1:0] & ADDR_MASK;
      end_seen   = word[END_BIT];
      res[0]     = walk_advance();
      n          = 1;
    end else if (walk_phase == WALK_DATA) begin
      res[0]     = mk(KIND_PORT, '0, word, 1'b0);
      words_left = words_left - 8'd1;
      res[1]     = walk_advance();
      n          = 2;
    end
    if (n > 0) res[n-1].last = 1'b1;
    out0 = res[0];
    out1 = res[1];
    return n;
  endfunction

  task automatic post(input int n, input result_t a, input result_t b);
    if (n > 0) pending_results.push_back(a);
    if (n > 1) pending_results.push_back(b);
  endtask

  task automatic send_item(input logic req, input logic [WORD_W-1:0] word);
    int gap;
    if (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_mem_word <= word;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    drain_results();
    if (idx == REG_LIST_BASE) base_reg = value[BASE_W-1:0];
    else from_ram_reg = value[0];
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_item(input logic req, input logic [WORD_W-1:0] word);
    row_t r;
    r     = '0;
    r.sel = req;
    r.val = word;
    dir_rows.push_back(r);
  endtask

  task automatic add_known(input logic req, input logic [WORD_W-1:0] word, input int n,
                           input result_t a, input result_t b);
    row_t r;
    r         = '0;
    r.sel     = req;
    r.val     = word;
    r.typed   = 1'b1;
    r.n_known = n[1:0];
    r.k0      = a;
    r.k1      = b;
    dir_rows.push_back(r);
  endtask

  task automatic add_write(input logic idx, input logic [31:0] value);
    row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.sel    = idx;
    r.val    = value;
    dir_rows.push_back(r);
  endtask

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = 80;
      end else if (stall_left == 0 && recv_stall_pct > 0 &&
                   $urandom_range(1, 100) <= recv_stall_pct) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result kind %0d with nothing pending", out_result_kind));
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind)
          flag_error($sformatf("kind %0d, want %0d", out_result_kind, want.kind));
        if (out_mem_address !== want.mem_address)
          flag_error($sformatf("address %h, want %h", out_mem_address, want.mem_address));
        if (out_port_word !== want.port_word)
          flag_error($sformatf("port word %h, want %h", out_port_word, want.port_word));
        if (out_last_of_run !== want.last)
          flag_error($sformatf("last %b, want %b", out_last_of_run, want.last));
      end
    end
  end

  initial begin
    row_t              row;
    result_t           a;
    result_t           b;
    int                n;
    int                walk_count;
    int                target;
    int                cnt;
    logic              req;
    logic [WORD_W-1:0] word;
    logic [31:0]       base_val;
    logic              from_val;
    bit                paused;

    // directed walks with register writes among them, starting from register reset values
    add_known(REQ_WORD, 32'hffffffff, 0, '0, '0);
    add_known(REQ_START, 32'h0, 1, mk(KIND_READ, 21'h0, '0, 1'b1), '0);
    add_known(REQ_WORD, 32'h021ffffc, 1, mk(KIND_READ, 21'h4, '0, 1'b1), '0);
    add_known(REQ_WORD, 32'hffffffff, 2, mk(KIND_PORT, '0, 32'hffffffff, 1'b0),
              mk(KIND_READ, 21'h8, '0, 1'b1));
    add_known(REQ_WORD, 32'h00000000, 2, mk(KIND_PORT, '0, 32'h0, 1'b0),
              mk(KIND_READ, 21'h1ffffc, '0, 1'b1));
    add_known(REQ_WORD, 32'hff800000, 1, mk(KIND_READ, 21'h0, '0, 1'b1), '0);
    add_item(REQ_WORD, 32'ha5a5a5a5);
    add_known(REQ_START, 32'hffffffff, 1, mk(KIND_READ, 21'h0, '0, 1'b1), '0);
    add_known(REQ_WORD, 32'h00800000, 1, mk(KIND_DONE, '0, '0, 1'b1), '0);
    add_known(REQ_WORD, 32'h7fffffff, 0, '0, '0);
    add_known(REQ_START, 32'h0, 1, mk(KIND_READ, 21'h0, '0, 1'b1), '0);
    add_item(REQ_WORD, 32'h00000abc);
    add_item(REQ_WORD, 32'hffffffff);
    add_item(REQ_WORD, 32'h5a5a5a5a);
    add_write(REG_FROM_RAM, 32'h0);
    add_known(REQ_START, 32'h0, 1, mk(KIND_DIRERR, '0, '0, 1'b1), '0);
    add_known(REQ_WORD, 32'h12345678, 0, '0, '0);
    add_write(REG_FROM_RAM, 32'h1);
    add_write(REG_LIST_BASE, 32'h00ffffff);
    add_known(REQ_START, 32'h0, 1, mk(KIND_READ, 21'h1ffffc, '0, 1'b1), '0);
    add_item(REQ_WORD, 32'h01800003);
    add_item(REQ_WORD, 32'h12345678);
    add_write(REG_LIST_BASE, 32'h00000003);
    add_known(REQ_START, 32'h0, 1, mk(KIND_READ, 21'h0, '0, 1'b1), '0);
    add_write(REG_FROM_RAM, 32'h0);
    add_known(REQ_START, 32'h0, 1, mk(KIND_DIRERR, '0, '0, 1'b1), '0);
    add_known(REQ_WORD, 32'hffffffff, 0, '0, '0);
    add_write(REG_FROM_RAM, 32'h1);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        write_reg(row.sel, row.val);
      end else begin
        n = predict_walk(row.sel, row.val, a, b);
        if (row.typed) post(row.n_known, row.k0, row.k1);
        else post(n, a, b);
        send_item(row.sel, row.val);
      end
    end

    // random walks, one register setting per phase
    for (int p = 0; p < 8; p++) begin
      base_val = (p == 0) ? 32'h0 : (p == 1) ? 32'hffffffff : $urandom;
      from_val = (p == 3) ? 1'b0 : 1'b1;
      write_reg(REG_LIST_BASE, base_val);
      write_reg(REG_FROM_RAM, ($urandom & 32'hfffffffe) | from_val);
      send_gap_pct   = (p == 2 || p == 5 || p == 7) ? 0 : 10;
      recv_stall_pct = (p == 5 || p == 7) ? 0 : 5;
      if (p == 2) long_hold_req = 1'b1;
      target     = (p == 3) ? 30 : 125;
      walk_count = 0;
      paused     = 1'b0;
      while (walk_count < target) begin
        word = $urandom;
        req  = REQ_WORD;
        if ($urandom_range(0, 99) < 8) begin
          req = 1'($urandom_range(0, 1));
        end else if (!from_ram_reg) begin
          req = 1'($urandom_range(0, 1));
        end else if (walk_phase == WALK_IDLE) begin
          req = REQ_START;
        end else if (walk_phase == WALK_HEADER) begin
          cnt = $urandom_range(0, 99);
          if (cnt < 85) cnt = $urandom_range(0, 5);
          else if (cnt < 97) cnt = $urandom_range(6, 40);
          else cnt = $urandom_range(41, 255);
          word[COUNT_LSB +: COUNT_W] = cnt[7:0];
          word[END_BIT]              = ($urandom_range(0, 2) == 0);
        end
        n = predict_walk(req, word, a, b);
        post(n, a, b);
        send_item(req, word);
        if (n > 0) walk_count++;
        if (p == 4 && walk_count == 60 && !paused) begin
          paused = 1'b1;
          drain_results();
        end
      end
    end

    drain_results();
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    $display("%0d input transfers (%0d directed rows), %0d result transfers checked",
             items_sent, dir_rows.size(), results_seen);
    $display("list base at both extremes and random, both directions, long output hold-off");
    if (err_count == 0) begin
      $display("dma_linked_list_walker_top verification clean");
    end else begin
      $display("dma_linked_list_walker_top verification failed");
    end
    $finish;
  end

endmodule
